>>> design/sfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_pkg
// Constants, register indexes and helper functions for the SENT frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GAIN_MODE  = 3'd0;
  localparam logic [2:0] REG_PRESS_OFS  = 3'd1;
  localparam logic [2:0] REG_STATUS     = 3'd2;
  localparam logic [2:0] REG_TICK_OFS   = 3'd3;
  localparam logic [2:0] REG_TICK_SCALE = 3'd4;

  // Register reset values
  localparam logic [1:0]  RST_GAIN_MODE  = 2'd0;
  localparam logic [11:0] RST_PRESS_OFS  = 12'd193;
  localparam logic [3:0]  RST_STATUS     = 4'd9;
  localparam logic [5:0]  RST_TICK_OFS   = 6'd12;
  localparam logic [3:0]  RST_TICK_SCALE = 4'd4;

  // Slot codes within one frame
  localparam logic [3:0] SLOT_SYNC   = 4'd0;
  localparam logic [3:0] SLOT_STATUS = 4'd1;
  localparam logic [3:0] SLOT_D0     = 4'd2;
  localparam logic [3:0] SLOT_D1     = 4'd3;
  localparam logic [3:0] SLOT_D2     = 4'd4;
  localparam logic [3:0] SLOT_D3     = 4'd5;
  localparam logic [3:0] SLOT_D4     = 4'd6;
  localparam logic [3:0] SLOT_D5     = 4'd7;
  localparam logic [3:0] SLOT_CRC    = 4'd8;

  // Temperature: count = (5*t + TEMP_BIAS) / 160, truncated toward zero
  localparam logic signed [19:0] TEMP_MUL  = 20'sd5;
  localparam logic signed [19:0] TEMP_BIAS = 20'sd93472;
  // x/5 == (x * RECIP5) >> 18 for x below 2^18
  localparam logic [15:0] RECIP5 = 16'd52429;

  localparam logic [3:0] CRC_SEED = 4'd5;

  // Pressure gain in Q7.16
  function automatic logic [22:0] gain_q16(input logic [1:0] mode);
    logic [22:0] g;
    case (mode)
      2'd0:    g = 23'd4853596;
      2'd1:    g = 23'd866714;
      2'd2:    g = 23'd577811;
      default: g = 23'd404469;
    endcase
    return g;
  endfunction

  // SENT CRC-4 table
  function automatic logic [3:0] crc_tab(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd13;
      4'd2:    r = 4'd7;
      4'd3:    r = 4'd10;
      4'd4:    r = 4'd14;
      4'd5:    r = 4'd3;
      4'd6:    r = 4'd9;
      4'd7:    r = 4'd4;
      4'd8:    r = 4'd1;
      4'd9:    r = 4'd12;
      4'd10:   r = 4'd6;
      4'd11:   r = 4'd11;
      4'd12:   r = 4'd15;
      4'd13:   r = 4'd2;
      4'd14:   r = 4'd8;
      default: r = 4'd5;
    endcase
    return r;
  endfunction

  // CRC over six data nibbles, most significant first, then one zero step
  function automatic logic [3:0] crc4(input logic [23:0] data);
    logic [3:0] c;
    c = CRC_SEED;
    for (int i = 5; i >= 0; i--) begin
      c = crc_tab(c) ^ data[i*4 +: 4];
    end
    c = crc_tab(c);
    return c;
  endfunction

endpackage

>>> design/sent_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sent_frame_encoder
// Turns one pressure/temperature reading into a nine-slot SENT frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one item per reading, pressure Q8.8 and temperature
//   Q8.8. Output stream (m_*): nine items per reading, slots sync, status,
//   six data nibbles and CRC, with tlast on the CRC slot.
//   Config port (cfg_*): always ready; write only while the block is idle.
//   Indexes beyond the register list are ignored.
// Path: after the input item is accepted, the first slot of a frame passes
//   through four compute stages, a frame buffer and the output register.
// Throughput: set by the output port, which sends one slot per cycle while
//   m_tready is high; the four compute stages take a new item every cycle
//   until full and fill up while a frame is being sent.
// Reset: registers return to their reset values, all stages empty.
// Stall: when m_tready is low the output register holds its slot, the frame
//   buffer and stages stop in place and s_tready falls once they are full.
// ----------------------------------------------------------------------------
module sent_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] pressure_q8, [31:16] temperature_q8
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] slot_index, [7:4] nibble_value,
                                 // [18:8] pulse_ticks, [23:19] zero
  output logic        m_tlast,   // last_slot
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  // configuration registers
  logic [1:0]  gain_mode;
  logic [11:0] pressure_offset;
  logic [3:0]  status_nibble;
  logic [5:0]  tick_offset;
  logic [3:0]  tick_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode       <= sfe_pkg::RST_GAIN_MODE;
      pressure_offset <= sfe_pkg::RST_PRESS_OFS;
      status_nibble   <= sfe_pkg::RST_STATUS;
      tick_offset     <= sfe_pkg::RST_TICK_OFS;
      tick_scale      <= sfe_pkg::RST_TICK_SCALE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfe_pkg::REG_GAIN_MODE:  gain_mode       <= cfg_data[1:0];
        sfe_pkg::REG_PRESS_OFS:  pressure_offset <= cfg_data;
        sfe_pkg::REG_STATUS:     status_nibble   <= cfg_data[3:0];
        sfe_pkg::REG_TICK_OFS:   tick_offset     <= cfg_data[5:0];
        sfe_pkg::REG_TICK_SCALE: tick_scale      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // flow control: each stage moves when empty or when the next one takes
  logic v1, v2, v3, v4;
  logic rdy2, rdy3, rdy4;
  logic fr_valid, fr_take, fr_fire, fr_last;
  logic [3:0] slot;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;
  assign fr_fire  = fr_valid && out_free;
  assign fr_last  = fr_fire && (slot == sfe_pkg::SLOT_CRC);
  assign fr_take  = !fr_valid || fr_last;
  assign rdy4     = !v4 || fr_take;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign s_tready = !v1 || rdy2;

  // stage 1: pressure gain product, temperature numerator magnitude
  logic signed [15:0] t_in;
  logic signed [19:0] tnum;
  logic [19:0]        tabs_full;
  logic [38:0]        s1_prod;
  logic [17:0]        s1_tabs;
  logic               s1_tneg;

  assign t_in      = signed'(s_tdata[31:16]);
  assign tnum      = 20'(t_in) * sfe_pkg::TEMP_MUL + sfe_pkg::TEMP_BIAS;
  assign tabs_full = tnum[19] ? 20'(-tnum) : 20'(tnum);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (s_tready) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_prod <= 39'(s_tdata[15:0]) * 39'(sfe_pkg::gain_q16(gain_mode));
      s1_tabs <= tabs_full[17:0];
      s1_tneg <= tnum[19];
    end
  end

  // stage 2: pressure count with offset, temperature divide by 32 then by 5
  logic [11:0] s2_pc;
  logic [28:0] s2_tprod;
  logic        s2_tneg;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (rdy2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_pc    <= s1_prod[35:24] + pressure_offset;
      s2_tprod <= 29'(s1_tabs[17:5]) * 29'(sfe_pkg::RECIP5);
      s2_tneg  <= s1_tneg;
    end
  end

  // stage 3: temperature quotient with sign, wrapped to 12 bits
  logic [10:0] tq;
  logic [11:0] s3_pc, s3_tc;

  assign tq = s2_tprod[28:18];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (rdy3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_pc <= s2_pc;
      s3_tc <= s2_tneg ? 12'(12'd0 - {1'b0, tq}) : {1'b0, tq};
    end
  end

  // stage 4: CRC-4 over the six data nibbles
  logic [23:0] s4_data;
  logic [3:0]  s4_crc;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (rdy4) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_data <= {s3_pc, s3_tc};
      s4_crc  <= sfe_pkg::crc4({s3_pc, s3_tc});
    end
  end

  // frame buffer and slot counter
  logic [23:0] fr_data;
  logic [3:0]  fr_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
      slot     <= sfe_pkg::SLOT_SYNC;
    end else if (fr_take && v4) begin
      fr_valid <= 1'b1;
      slot     <= sfe_pkg::SLOT_SYNC;
    end else if (fr_last) begin
      fr_valid <= 1'b0;
    end else if (fr_fire) begin
      slot <= slot + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_take && v4) begin
      fr_data <= s4_data;
      fr_crc  <= s4_crc;
    end
  end

  // nibble for the current slot
  logic [3:0] nib;

  always_comb begin
    unique case (slot)
      sfe_pkg::SLOT_SYNC:   nib = 4'd0;
      sfe_pkg::SLOT_STATUS: nib = status_nibble;
      sfe_pkg::SLOT_D0:     nib = fr_data[23:20];
      sfe_pkg::SLOT_D1:     nib = fr_data[19:16];
      sfe_pkg::SLOT_D2:     nib = fr_data[15:12];
      sfe_pkg::SLOT_D3:     nib = fr_data[11:8];
      sfe_pkg::SLOT_D4:     nib = fr_data[7:4];
      sfe_pkg::SLOT_D5:     nib = fr_data[3:0];
      default:              nib = fr_crc;
    endcase
  end

  // pulse width and output register
  logic [6:0]  ticks;
  logic [10:0] pulse;

  assign ticks = {3'b000, nib} + {1'b0, tick_offset};
  assign pulse = 11'(11'(ticks) * 11'(tick_scale));

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_free) m_tvalid <= fr_valid;
  end

  always_ff @(posedge clk) begin
    if (fr_fire) begin
      m_tdata <= {5'b00000, pulse, nib, slot};
      m_tlast <= (slot == sfe_pkg::SLOT_CRC);
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SENT frame encoder. Pressure/temperature
// readings go in on the input stream; a local model predicts the nine slots
// of each frame, and every slot on the output stream is compared with the
// oldest prediction. Phases change the configuration registers while the
// block is idle. Both streams idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

  // One output slot as predicted
  typedef struct packed {
    logic [3:0]  slot;
    logic [3:0]  nibble;
    logic [10:0] pulse;
    logic        last;
  } sent_slot_t;

  // Register indexes outside the register list
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Gain selections
  localparam logic [1:0] GAIN_74 = 2'd0;
  localparam logic [1:0] GAIN_13 = 2'd1;
  localparam logic [1:0] GAIN_8  = 2'd2;
  localparam logic [1:0] GAIN_6  = 2'd3;

  // SENT CRC-4 lookup, entry 15 in the top nibble
  localparam logic [63:0] SENT_CRC_LUT = {
    4'd5, 4'd8, 4'd2, 4'd15, 4'd11, 4'd6, 4'd12, 4'd1,
    4'd4, 4'd9, 4'd3, 4'd14, 4'd10, 4'd7, 4'd13, 4'd0
  };

  localparam int TEMP_OFFSET_NUM = 93472;
  localparam int TEMP_DIV        = 160;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_ITEMS     = 27;
  localparam int MAX_REPORTS     = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  sent_frame_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Local copy of the configuration registers
  logic [1:0]  cur_gain     = sfe_pkg::RST_GAIN_MODE;
  logic [11:0] cur_press_ofs = sfe_pkg::RST_PRESS_OFS;
  logic [3:0]  cur_status   = sfe_pkg::RST_STATUS;
  logic [5:0]  cur_tick_ofs = sfe_pkg::RST_TICK_OFS;
  logic [3:0]  cur_scale    = sfe_pkg::RST_TICK_SCALE;

  logic [31:0] pending_readings[$];
  sent_slot_t  expected_slots[$];
  int          fail_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;

  function automatic void apply_reg(input logic [2:0] idx, input logic [11:0] val);
    case (idx)
      sfe_pkg::REG_GAIN_MODE:  cur_gain      = val[1:0];
      sfe_pkg::REG_PRESS_OFS:  cur_press_ofs = val;
      sfe_pkg::REG_STATUS:     cur_status    = val[3:0];
      sfe_pkg::REG_TICK_OFS:   cur_tick_ofs  = val[5:0];
      sfe_pkg::REG_TICK_SCALE: cur_scale     = val[3:0];
      default: ;
    endcase
  endfunction

  // Pressure gain in Q7.16
  function automatic logic [22:0] gain_of(input logic [1:0] mode);
    logic [22:0] g;
    case (mode)
      GAIN_74: g = 23'd4853596;
      GAIN_13: g = 23'd866714;
      GAIN_8:  g = 23'd577811;
      default: g = 23'd404469;
    endcase
    return g;
  endfunction

  function automatic sent_slot_t make_slot(input logic [3:0] slot, input logic [3:0] nib);
    sent_slot_t s;
    s.slot   = slot;
    s.nibble = nib;
    s.pulse  = (11'(nib) + 11'(cur_tick_ofs)) * 11'(cur_scale);
    s.last   = (slot == sfe_pkg::SLOT_CRC);
    return s;
  endfunction

  // Predict the nine slots of the frame for one reading
  task automatic predict_frame(input logic [15:0] press, input logic [15:0] temp);
    logic [38:0] prod;
    logic [11:0] pc;
    logic [11:0] tc;
    logic [23:0] data;
    logic [3:0]  crc;
    int          tv;
    int          num;
    int          q;
    prod = 39'(press) * 39'(gain_of(cur_gain));
    pc   = prod[35:24] + cur_press_ofs;
    tv   = $signed(temp);
    num  = 5 * tv + TEMP_OFFSET_NUM;
    q    = num / TEMP_DIV;      // truncates toward zero
    tc   = q[11:0];
    data = {pc, tc};
    crc  = sfe_pkg::CRC_SEED;
    for (int i = 5; i >= 0; i--) begin
      crc = SENT_CRC_LUT[crc*4 +: 4] ^ data[i*4 +: 4];
    end
    crc = SENT_CRC_LUT[crc*4 +: 4];
    expected_slots.push_back(make_slot(sfe_pkg::SLOT_SYNC, 4'd0));
    expected_slots.push_back(make_slot(sfe_pkg::SLOT_STATUS, cur_status));
    for (int i = 0; i < 6; i++) begin
      expected_slots.push_back(make_slot(sfe_pkg::SLOT_D0 + 4'(i), data[(5-i)*4 +: 4]));
    end
    expected_slots.push_back(make_slot(sfe_pkg::SLOT_CRC, crc));
  endtask

  // Reading driver: feeds pending items, random gaps after acceptance
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_frame(s_tdata[15:0], s_tdata[31:16]);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_readings.size() > 0) begin
          s_tdata  <= pending_readings.pop_front();
          s_tvalid <= 1'b1;
          if (src_idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Slot checker: compares each accepted slot with the oldest prediction
  int sink_gap = 0;
  always @(posedge clk) begin
    sent_slot_t got;
    sent_slot_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.slot   = m_tdata[3:0];
        got.nibble = m_tdata[7:4];
        got.pulse  = m_tdata[18:8];
        got.last   = m_tlast;
        if (expected_slots.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected slot: slot=%0d nibble=%0d pulse=%0d last=%0b",
                     got.slot, got.nibble, got.pulse, got.last);
        end else begin
          want = expected_slots.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("slot mismatch: exp slot=%0d nibble=%0d pulse=%0d last=%0b",
                       want.slot, want.nibble, want.pulse, want.last);
              $display("               got slot=%0d nibble=%0d pulse=%0d last=%0b",
                       got.slot, got.nibble, got.pulse, got.last);
            end
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 13);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic add_reading(input logic [15:0] press, input logic [15:0] temp);
    pending_readings.push_back({temp, press});
  endtask

  // Half full-range readings, a quarter realistic, a quarter near the zero-count edge
  task automatic add_random_readings(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0, 1: pending_readings.push_back($urandom);
        2:    add_reading(16'($urandom_range(0, 4095)),
                          16'(int'($urandom_range(0, 200)) - 18800));
        default: add_reading(16'($urandom), 16'(int'($urandom_range(0, 43007)) - 10240));
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_readings.size() != 0 || s_tvalid || expected_slots.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_config();
    write_reg(sfe_pkg::REG_GAIN_MODE, 12'($urandom));
    write_reg(sfe_pkg::REG_PRESS_OFS, 12'($urandom));
    write_reg(sfe_pkg::REG_STATUS, 12'($urandom));
    write_reg(sfe_pkg::REG_TICK_OFS, 12'($urandom));
    write_reg(sfe_pkg::REG_TICK_SCALE, 12'($urandom));
  endtask

  // random values for every register except the gain selection
  task automatic random_config_rest();
    write_reg(sfe_pkg::REG_PRESS_OFS, 12'($urandom));
    write_reg(sfe_pkg::REG_STATUS, 12'($urandom));
    write_reg(sfe_pkg::REG_TICK_OFS, 12'($urandom));
    write_reg(sfe_pkg::REG_TICK_SCALE, 12'($urandom));
  endtask

  // Phase sequencing
  initial begin
    // field extremes and the temperature zero crossing at reset settings
    add_reading(16'h0000, 16'h0000);
    add_reading(16'hFFFF, 16'h7FFF);
    add_reading(16'hFFFF, 16'h8000);
    add_reading(16'h0000, 16'h8000);
    add_reading(16'h0000, 16'h7FFF);
    add_reading(16'h8000, 16'h0000);
    add_reading(16'h0001, 16'hFFFF);
    add_reading(16'hAAAA, 16'h5555);
    add_reading(16'h5555, 16'hAAAA);
    add_reading(16'h1900, 16'h1900);
    add_reading(16'h0100, -16'sd18662);   // just above zero count
    add_reading(16'h0200, -16'sd18694);   // small positive numerator
    add_reading(16'h0300, -16'sd18695);   // small negative, truncates to zero
    add_reading(16'h0400, -16'sd18726);   // largest negative still zero
    add_reading(16'h0500, -16'sd18727);   // wraps to 0xFFF
    add_reading(16'h0600, -16'sd18758);
    add_reading(16'h7FFF, 16'h0001);
    add_reading(16'h00FF, 16'hFF00);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // low extremes, zero tick scale
    write_reg(sfe_pkg::REG_GAIN_MODE, 12'(GAIN_6));
    write_reg(sfe_pkg::REG_PRESS_OFS, 12'd0);
    write_reg(sfe_pkg::REG_STATUS, 12'd0);
    write_reg(sfe_pkg::REG_TICK_OFS, 12'd0);
    write_reg(sfe_pkg::REG_TICK_SCALE, 12'd0);
    add_reading(16'hFFFF, 16'h7FFF);
    add_random_readings(PHASE_ITEMS);
    wait_drained();

    // high extremes, junk upper bits, spare indexes ignored
    write_reg(sfe_pkg::REG_GAIN_MODE, 12'hFFC);
    write_reg(sfe_pkg::REG_PRESS_OFS, 12'hFFF);
    write_reg(sfe_pkg::REG_STATUS, 12'hFFF);
    write_reg(sfe_pkg::REG_TICK_OFS, 12'hFFF);
    write_reg(sfe_pkg::REG_TICK_SCALE, 12'hFFF);
    write_reg(REG_SPARE_LO, 12'h5A5);
    write_reg(REG_SPARE_HI, 12'hA5A);
    add_reading(16'hFFFF, 16'h7FFF);
    add_random_readings(PHASE_ITEMS);
    wait_drained();

    // sender holds off mid-phase until every slot is out
    write_reg(sfe_pkg::REG_GAIN_MODE, 12'(GAIN_13));
    random_config_rest();
    add_random_readings(PHASE_ITEMS / 2);
    wait_drained();
    add_random_readings(PHASE_ITEMS - PHASE_ITEMS / 2);
    wait_drained();

    write_reg(sfe_pkg::REG_GAIN_MODE, 12'(GAIN_8));
    random_config_rest();
    src_idle_on  = 1'b0;
    add_random_readings(PHASE_ITEMS);
    wait_drained();

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b0;
    random_config();
    add_random_readings(PHASE_ITEMS);
    wait_drained();

    sink_idle_on = 1'b1;
    random_config();
    add_random_readings(PHASE_ITEMS);
    wait_drained();

    // closing stretch with no idling
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_config();
    add_random_readings(PHASE_ITEMS);
    wait_drained();
    repeat (20) @(negedge clk);

    if (fail_count == 0 && expected_slots.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
